// ===== rtl/core/pp2s_pkg.sv =====
`default_nettype none

package pp2s_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_ROW_X    = 3'd0;
  localparam logic [2:0] CFG_ROW_Y    = 3'd1;
  localparam logic [2:0] CFG_ROW_Z    = 3'd2;
  localparam logic [2:0] CFG_ROW_W    = 3'd3;
  localparam logic [2:0] CFG_VIEWPORT = 3'd4;
  localparam logic [2:0] CFG_ZERO_TOL = 3'd5;

  // off-screen handling modes
  localparam logic [1:0] MODE_SQUARE = 2'd0;
  localparam logic [1:0] MODE_CIRCLE = 2'd1;
  localparam logic [1:0] MODE_NONE   = 2'd2;

  // fixed point constants
  localparam int HALF_Q16   = 32768;
  localparam int ONE_Q16    = 65536;
  localparam int EIGHTH_Q32 = 536870912;

  // pipeline sizes
  localparam int ACC_W      = 46;
  localparam int QUO_W      = 32;
  localparam int SQRT_STEPS = 32;
  localparam int CIRC_W     = 16;
  localparam int SQR_W      = 18;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef logic signed [ACC_W-1:0] acc_t;

  // projected point handed from the divide section to the remap section
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] depth;
    logic               vis;
    logic               wz;
    logic               remap;
    logic               mode_sq;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } proj_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic               visible;
    logic               w_zero;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fff_ffff;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pp2s_matrix.sv =====
`default_nettype none

module pp2s_matrix (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic [1:0]          mode,
  input  wire logic [63:0]         row_x,
  input  wire logic [63:0]         row_y,
  input  wire logic [63:0]         row_z,
  input  wire logic [63:0]         row_w,
  output logic                     out_valid,
  output pp2s_pkg::acc_t           out_xa,
  output pp2s_pkg::acc_t           out_ya,
  output pp2s_pkg::acc_t           out_za,
  output pp2s_pkg::acc_t           out_wa,
  output logic [1:0]               out_mode
);

  logic [63:0]        rows [4];
  logic signed [31:0] pos [3];
  logic signed [43:0] prod_nxt [4][3];
  logic signed [43:0] prod_r [4][3];
  logic signed [37:0] trn_nxt [4];
  logic signed [37:0] trn_r [4];
  pp2s_pkg::acc_t     sum_nxt [4];
  pp2s_pkg::acc_t     sum_r [4];
  logic [1:0]         mode1_r, mode2_r;
  logic               v1_r, v2_r;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;
  assign rows[3] = row_w;
  assign pos[0]  = pos_x;
  assign pos[1]  = pos_y;
  assign pos[2]  = pos_z;

  // coefficient products and scaled translation
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = 44'(pos[j]) * 44'($signed(rows[i][12*j +: 12]));
      end
      trn_nxt[i] = $signed({rows[i][63:36], 10'b0});
    end
  end

  // row sums in q.18
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_nxt[i] = pp2s_pkg::ACC_W'(prod_r[i][0]) + pp2s_pkg::ACC_W'(prod_r[i][1])
                 + pp2s_pkg::ACC_W'(prod_r[i][2]) + pp2s_pkg::ACC_W'(trn_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      trn_r   <= trn_nxt;
      mode1_r <= mode;
      sum_r   <= sum_nxt;
      mode2_r <= mode1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_xa    = sum_r[0];
  assign out_ya    = sum_r[1];
  assign out_za    = sum_r[2];
  assign out_wa    = sum_r[3];
  assign out_mode  = mode2_r;

endmodule

`default_nettype wire

// ===== rtl/core/pp2s_persp.sv =====
`default_nettype none

module pp2s_persp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire pp2s_pkg::acc_t      xa,
  input  wire pp2s_pkg::acc_t      ya,
  input  wire pp2s_pkg::acc_t      za,
  input  wire pp2s_pkg::acc_t      wa,
  input  wire logic [1:0]          mode,
  input  wire logic [63:0]         viewport,
  input  wire logic signed [31:0]  zero_tol,
  output logic                     out_valid,
  output pp2s_pkg::proj_t          out_proj
);

  localparam int NQ = pp2s_pkg::QUO_W;

  typedef struct packed {
    logic [61:0]    rem;
    logic [NQ-1:0]  quo;
    logic           neg;
    logic           ovf;
  } lane_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               wz;
    logic               behind;
    logic signed [31:0] raw_x;
    logic signed [31:0] raw_y;
    logic [45:0]        dmag;
  } pside_t;

  function automatic logic signed [31:0] quo_sat(input lane_t ln);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = ln.neg ? -$signed({1'b0, ln.quo}) : $signed({1'b0, ln.quo});
    if (ln.ovf) r = ln.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = pp2s_pkg::sat32(64'(s));
    return r;
  endfunction

  pp2s_pkg::acc_t     a_in [3];
  lane_t              dv_nxt [NQ+1][3];
  lane_t              dv_r [NQ+1][3];
  pside_t             ps_nxt;
  pside_t             ps_r [NQ+1];
  logic               pv_r [NQ+1];
  logic [45:0]        wmag;

  logic [15:0]        vl, vr, vt, vb;
  logic signed [16:0] rl_d, tb_d;
  logic [16:0]        rl_s, tb_s;

  logic signed [32:0] nbx_nxt, nby_nxt, nbx_r, nby_r;
  logic signed [31:0] qd_nxt, qd_r, qx, qy;
  pside_t             qs_r;
  logic               qv_r;

  logic signed [49:0] px_nxt, py_nxt, px_r, py_r;
  logic signed [31:0] v1d_r;
  pside_t             v1s_r;
  logic               v1v_r;

  logic signed [31:0] sx_nxt, sy_nxt, sx_r, sy_r, v2d_r;
  pside_t             v2s_r;
  logic               v2v_r;

  pp2s_pkg::proj_t    pj_nxt, pj_r;
  logic               pjv_r;
  logic               in_view;

  assign a_in[0] = xa;
  assign a_in[1] = ya;
  assign a_in[2] = za;
  assign vl = viewport[15:0];
  assign vr = viewport[31:16];
  assign vt = viewport[47:32];
  assign vb = viewport[63:48];
  assign rl_d = $signed({1'b0, vr}) - $signed({1'b0, vl});
  assign tb_d = $signed({1'b0, vt}) - $signed({1'b0, vb});
  assign rl_s = {1'b0, vr} + {1'b0, vl};
  assign tb_s = {1'b0, vt} + {1'b0, vb};

  // divider setup: magnitudes, quotient sign, overflow and side flags
  always_comb begin
    logic [45:0] amag;
    wmag = wa[45] ? 46'(-wa) : 46'(wa);
    for (int c = 0; c < 3; c++) begin
      amag = a_in[c][45] ? 46'(-a_in[c]) : 46'(a_in[c]);
      dv_nxt[0][c].rem = {amag, 16'b0};
      dv_nxt[0][c].quo = '0;
      dv_nxt[0][c].neg = a_in[c][45] ^ wa[45];
      dv_nxt[0][c].ovf = 62'(amag) >= {wmag, 16'b0};
    end
    ps_nxt.mode   = mode;
    ps_nxt.wz     = (wa == '0);
    ps_nxt.behind = !(wa > pp2s_pkg::ACC_W'($signed({zero_tol, 10'b0})));
    ps_nxt.raw_x  = pp2s_pkg::sat32(64'(xa >>> 2));
    ps_nxt.raw_y  = pp2s_pkg::sat32(64'(ya >>> 2));
    ps_nxt.dmag   = wmag;
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < NQ; k++) begin : g_div
    localparam int B = NQ - 1 - k;
    always_comb begin
      logic [77:0] dsh;
      dsh = 78'(ps_r[k].dmag) << B;
      for (int c = 0; c < 3; c++) begin
        dv_nxt[k+1][c] = dv_r[k][c];
        if (78'(dv_r[k][c].rem) >= dsh) begin
          dv_nxt[k+1][c].rem    = dv_r[k][c].rem - dsh[61:0];
          dv_nxt[k+1][c].quo[B] = 1'b1;
        end
      end
    end
  end

  // saturate quotients, negate behind-camera points
  always_comb begin
    qx = quo_sat(dv_r[NQ][0]);
    qy = quo_sat(dv_r[NQ][1]);
    nbx_nxt = ps_r[NQ].behind ? -33'(qx) : 33'(qx);
    nby_nxt = ps_r[NQ].behind ? -33'(qy) : 33'(qy);
    qd_nxt  = ps_r[NQ].wz ? '0 : quo_sat(dv_r[NQ][2]);
  end

  // viewport scale products
  assign px_nxt = 50'(nbx_r) * 50'(rl_d);
  assign py_nxt = 50'(nby_r) * 50'(tb_d);

  // viewport offset, y flip, saturation
  always_comb begin
    if (v1s_r.wz) begin
      sx_nxt = v1s_r.raw_x;
      sy_nxt = v1s_r.raw_y;
    end else begin
      sx_nxt = pp2s_pkg::sat32(64'(px_r >>> 16) + $signed(64'(rl_s)));
      sy_nxt = pp2s_pkg::sat32($signed(64'({vt, 1'b0}))
                               - (64'(py_r >>> 16) + $signed(64'(tb_s))));
    end
  end

  // visibility and remap decision
  always_comb begin
    in_view = (sx_r >= $signed({15'b0, vl, 1'b0})) && (sx_r <= $signed({15'b0, vr, 1'b0}))
           && (sy_r >= $signed({15'b0, vb, 1'b0})) && (sy_r <= $signed({15'b0, vt, 1'b0}));
    pj_nxt.sx      = sx_r;
    pj_nxt.sy      = sy_r;
    pj_nxt.depth   = v2d_r;
    pj_nxt.wz      = v2s_r.wz;
    pj_nxt.vis     = in_view && !v2s_r.behind && !v2s_r.wz;
    pj_nxt.remap   = !pj_nxt.vis && !v2s_r.wz
                   && (v2s_r.mode == pp2s_pkg::MODE_SQUARE || v2s_r.mode == pp2s_pkg::MODE_CIRCLE);
    pj_nxt.mode_sq = (v2s_r.mode == pp2s_pkg::MODE_SQUARE);
    pj_nxt.dx      = 33'(sx_r) - $signed({17'b0, vr});
    pj_nxt.dy      = 33'(sy_r) - $signed({17'b0, vt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NQ; k++) pv_r[k] <= 1'b0;
      qv_r  <= 1'b0;
      v1v_r <= 1'b0;
      v2v_r <= 1'b0;
      pjv_r <= 1'b0;
    end else if (en) begin
      pv_r[0] <= in_valid;
      for (int k = 0; k < NQ; k++) pv_r[k+1] <= pv_r[k];
      qv_r  <= pv_r[NQ];
      v1v_r <= qv_r;
      v2v_r <= v1v_r;
      pjv_r <= v2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_nxt[0];
      ps_r[0] <= ps_nxt;
      for (int k = 0; k < NQ; k++) begin
        dv_r[k+1] <= dv_nxt[k+1];
        ps_r[k+1] <= ps_r[k];
      end
      nbx_r <= nbx_nxt;
      nby_r <= nby_nxt;
      qd_r  <= qd_nxt;
      qs_r  <= ps_r[NQ];
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      v1d_r <= qd_r;
      v1s_r <= qs_r;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      v2d_r <= v1d_r;
      v2s_r <= v1s_r;
      pj_r  <= pj_nxt;
    end
  end

  assign out_valid = pjv_r;
  assign out_proj  = pj_r;

endmodule

`default_nettype wire

// ===== rtl/core/pp2s_remap.sv =====
`default_nettype none

module pp2s_remap (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire pp2s_pkg::proj_t  in_proj,
  input  wire logic [63:0]      viewport,
  output logic                  out_valid,
  output pp2s_pkg::result_t     out_res
);

  localparam int NS = pp2s_pkg::SQRT_STEPS;
  localparam int NC = pp2s_pkg::CIRC_W;
  localparam int NE = pp2s_pkg::SQR_W;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } root_t;

  typedef struct packed {
    logic [48:0]   rem;
    logic [NC-1:0] quo;
    logic          neg;
  } clane_t;

  typedef struct packed {
    logic [33:0]   rem;
    logic [NE-1:0] quo;
    logic          neg;
    logic          pos;
    logic          ovf;
  } slane_t;

  typedef struct packed {
    logic [NE-1:0]      dv;
    logic               divz;
    logic signed [18:0] csx;
    logic signed [18:0] csy;
  } sside_t;

  function automatic logic [16:0] clamp01(input logic signed [20:0] v);
    logic [16:0] r;
    if (v < 0) r = '0;
    else if (v > 21'(pp2s_pkg::ONE_Q16)) r = 17'(pp2s_pkg::ONE_Q16);
    else r = v[16:0];
    return r;
  endfunction

  function automatic logic [16:0] sq_coord(input slane_t ln, input logic divz);
    logic [NE:0]        qm;
    logic signed [20:0] sv;
    logic [16:0]        r;
    qm = ln.ovf ? (NE+1)'(1) << NE : {1'b0, ln.quo};
    sv = ln.neg ? -$signed(21'(qm)) : $signed(21'(qm));
    if (divz) r = ln.pos ? 17'(pp2s_pkg::ONE_Q16) : '0;
    else r = clamp01((sv >>> 1) + 21'(pp2s_pkg::HALF_Q16));
    return r;
  endfunction

  logic [15:0]        vr, vt;
  logic signed [65:0] sqx_full, sqy_full;
  logic [63:0]        sqx_r, sqy_r;
  pp2s_pkg::proj_t    pa_r;
  logic               va_r;

  root_t              sr_nxt [NS+1];
  root_t              sr_r [NS+1];
  pp2s_pkg::proj_t    sp_r [NS+1];
  logic               sv_r [NS+1];

  logic [31:0]        d_r;
  logic signed [49:0] prx_r, pry_r;
  pp2s_pkg::proj_t    pc_r;
  logic               vc_r;

  clane_t             cd_nxt [NC+1][2];
  clane_t             cd_r [NC+1][2];
  logic [31:0]        cdv_r [NC+1];
  pp2s_pkg::proj_t    cp_r [NC+1];
  logic               cv_r [NC+1];

  logic signed [18:0] csx_nxt, csy_nxt, csx_r, csy_r, ex_r, ey_r, qsx, qsy;
  pp2s_pkg::proj_t    pe_r;
  logic               ve_r;

  logic signed [37:0] eysq_r;
  logic signed [18:0] fex_r, fey_r, fcsx_r, fcsy_r;
  pp2s_pkg::proj_t    pf_r;
  logic               vf_r;

  slane_t             sd_nxt [NE+1][2];
  slane_t             sd_r [NE+1][2];
  sside_t             ss_nxt;
  sside_t             ss_r [NE+1];
  pp2s_pkg::proj_t    qp_r [NE+1];
  logic               qv_r [NE+1];

  pp2s_pkg::result_t  res_nxt, res_r;
  logic               vres_r;

  assign vr = viewport[31:16];
  assign vt = viewport[47:32];

  // squared distances from the circle center
  assign sqx_full = 66'(in_proj.dx) * 66'(in_proj.dx);
  assign sqy_full = 66'(in_proj.dy) * 66'(in_proj.dy);

  assign sr_nxt[0].rem = sqx_r + sqy_r;
  assign sr_nxt[0].res = '0;

  // integer square root, two radicand bits per stage
  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam int SH = 2*(NS-1-k);
    always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      bitv  = 64'(1) << SH;
      trial = sr_r[k].res + bitv;
      if (sr_r[k].rem >= trial) begin
        sr_nxt[k+1].rem = sr_r[k].rem - trial;
        sr_nxt[k+1].res = (sr_r[k].res >> 1) + bitv;
      end else begin
        sr_nxt[k+1].rem = sr_r[k].rem;
        sr_nxt[k+1].res = sr_r[k].res >> 1;
      end
    end
  end

  // circle divide setup
  always_comb begin
    cd_nxt[0][0].rem = prx_r[49] ? 49'(-prx_r) : 49'(prx_r);
    cd_nxt[0][0].quo = '0;
    cd_nxt[0][0].neg = prx_r[49];
    cd_nxt[0][1].rem = pry_r[49] ? 49'(-pry_r) : 49'(pry_r);
    cd_nxt[0][1].quo = '0;
    cd_nxt[0][1].neg = pry_r[49];
  end

  for (genvar k = 0; k < NC; k++) begin : g_cdiv
    localparam int B = NC - 1 - k;
    always_comb begin
      logic [63:0] dsh;
      dsh = 64'(cdv_r[k]) << B;
      for (int c = 0; c < 2; c++) begin
        cd_nxt[k+1][c] = cd_r[k][c];
        if (64'(cd_r[k][c].rem) >= dsh) begin
          cd_nxt[k+1][c].rem    = cd_r[k][c].rem - dsh[48:0];
          cd_nxt[k+1][c].quo[B] = 1'b1;
        end
      end
    end
  end

  // point pulled onto the circle; a zero distance leaves it at the center
  always_comb begin
    logic [NC-1:0] qx, qy;
    qx  = (cdv_r[NC] == '0) ? '0 : cd_r[NC][0].quo;
    qy  = (cdv_r[NC] == '0) ? '0 : cd_r[NC][1].quo;
    qsx = $signed(19'(qx));
    qsy = $signed(19'(qy));
    csx_nxt = $signed(19'(vr)) + (cd_r[NC][0].neg ? -qsx : qsx);
    csy_nxt = $signed(19'(vt)) + (cd_r[NC][1].neg ? -qsy : qsy);
  end

  // square divide setup
  always_comb begin
    logic [NE-1:0] mex, mey, dv;
    mex = fex_r[18] ? NE'(-fex_r) : NE'(fex_r);
    mey = fey_r[18] ? NE'(-fey_r) : NE'(fey_r);
    dv  = (eysq_r > 38'(pp2s_pkg::EIGHTH_Q32)) ? mey : mex;
    sd_nxt[0][0].rem = {mex, 16'b0};
    sd_nxt[0][0].quo = '0;
    sd_nxt[0][0].neg = fex_r[18];
    sd_nxt[0][0].pos = !fex_r[18] && (fex_r != '0);
    sd_nxt[0][0].ovf = 36'({mex, 16'b0}) >= {dv, 18'b0};
    sd_nxt[0][1].rem = {mey, 16'b0};
    sd_nxt[0][1].quo = '0;
    sd_nxt[0][1].neg = fey_r[18];
    sd_nxt[0][1].pos = !fey_r[18] && (fey_r != '0);
    sd_nxt[0][1].ovf = 36'({mey, 16'b0}) >= {dv, 18'b0};
    ss_nxt.dv   = dv;
    ss_nxt.divz = (dv == '0);
    ss_nxt.csx  = fcsx_r;
    ss_nxt.csy  = fcsy_r;
  end

  for (genvar k = 0; k < NE; k++) begin : g_sdiv
    localparam int B = NE - 1 - k;
    always_comb begin
      logic [63:0] dsh;
      dsh = 64'(ss_r[k].dv) << B;
      for (int c = 0; c < 2; c++) begin
        sd_nxt[k+1][c] = sd_r[k][c];
        if (64'(sd_r[k][c].rem) >= dsh) begin
          sd_nxt[k+1][c].rem    = sd_r[k][c].rem - dsh[33:0];
          sd_nxt[k+1][c].quo[B] = 1'b1;
        end
      end
    end
  end

  // final selection between plain, circle and square results
  always_comb begin
    pp2s_pkg::proj_t p;
    p = qp_r[NE];
    res_nxt.depth   = p.depth;
    res_nxt.visible = p.vis;
    res_nxt.w_zero  = p.wz;
    if (!p.remap) begin
      res_nxt.screen_x = p.sx;
      res_nxt.screen_y = p.sy;
    end else if (p.mode_sq) begin
      res_nxt.screen_x = 32'(sq_coord(sd_r[NE][0], ss_r[NE].divz));
      res_nxt.screen_y = 32'(sq_coord(sd_r[NE][1], ss_r[NE].divz));
    end else begin
      res_nxt.screen_x = 32'(clamp01(21'(ss_r[NE].csx)));
      res_nxt.screen_y = 32'(clamp01(21'(ss_r[NE].csy)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      for (int k = 0; k <= NS; k++) sv_r[k] <= 1'b0;
      vc_r <= 1'b0;
      for (int k = 0; k <= NC; k++) cv_r[k] <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      for (int k = 0; k <= NE; k++) qv_r[k] <= 1'b0;
      vres_r <= 1'b0;
    end else if (en) begin
      va_r    <= in_valid;
      sv_r[0] <= va_r;
      for (int k = 0; k < NS; k++) sv_r[k+1] <= sv_r[k];
      vc_r    <= sv_r[NS];
      cv_r[0] <= vc_r;
      for (int k = 0; k < NC; k++) cv_r[k+1] <= cv_r[k];
      ve_r    <= cv_r[NC];
      vf_r    <= ve_r;
      qv_r[0] <= vf_r;
      for (int k = 0; k < NE; k++) qv_r[k+1] <= qv_r[k];
      vres_r  <= qv_r[NE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r   <= sqx_full[63:0];
      sqy_r   <= sqy_full[63:0];
      pa_r    <= in_proj;
      sr_r[0] <= sr_nxt[0];
      sp_r[0] <= pa_r;
      for (int k = 0; k < NS; k++) begin
        sr_r[k+1] <= sr_nxt[k+1];
        sp_r[k+1] <= sp_r[k];
      end
      d_r     <= sr_r[NS].res[31:0];
      prx_r   <= 50'(sp_r[NS].dx) * $signed(50'(vt));
      pry_r   <= 50'(sp_r[NS].dy) * $signed(50'(vt));
      pc_r    <= sp_r[NS];
      cd_r[0] <= cd_nxt[0];
      cdv_r[0] <= d_r;
      cp_r[0] <= pc_r;
      for (int k = 0; k < NC; k++) begin
        cd_r[k+1]  <= cd_nxt[k+1];
        cdv_r[k+1] <= cdv_r[k];
        cp_r[k+1]  <= cp_r[k];
      end
      csx_r   <= csx_nxt;
      csy_r   <= csy_nxt;
      ex_r    <= csx_nxt - 19'sd32768;
      ey_r    <= csy_nxt - 19'sd32768;
      pe_r    <= cp_r[NC];
      eysq_r  <= 38'(ey_r) * 38'(ey_r);
      fex_r   <= ex_r;
      fey_r   <= ey_r;
      fcsx_r  <= csx_r;
      fcsy_r  <= csy_r;
      pf_r    <= pe_r;
      sd_r[0] <= sd_nxt[0];
      ss_r[0] <= ss_nxt;
      qp_r[0] <= pf_r;
      for (int k = 0; k < NE; k++) begin
        sd_r[k+1] <= sd_nxt[k+1];
        ss_r[k+1] <= ss_r[k];
        qp_r[k+1] <= qp_r[k];
      end
      res_r   <= res_nxt;
    end
  end

  assign out_valid = vres_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/perspective_project_to_screen_top.sv =====
`default_nettype none

// channel  | ports                        | contents
// in       | in_tvalid/in_tready          | tdata: pos_x, pos_y, pos_z; tuser: offscreen_mode
// out      | out_tvalid/out_tready        | tdata: screen_x, screen_y, depth; tuser: visible, w_zero
// cfg      | cfg_valid/cfg_ready          | cfg_index selects register, cfg_data is the value
//
// one point is accepted per clock while the output buffer has room; each result passes through
// the three restoring dividers and the square-root pipeline (one bit or digit per stage)
// reset clears all valid bits and the configuration registers to zero
// the whole pipeline holds while the two-entry output buffer is full
// configuration writes are always taken, but later stages read the registers directly,
// so writes belong where no point is in flight

module perspective_project_to_screen_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // pos_x, pos_y, pos_z
  input  wire logic [1:0]   in_tuser,   // offscreen_mode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // screen_x, screen_y, depth
  output logic [1:0]        out_tuser,  // visible, w_zero
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  logic [63:0]        row_x_r, row_y_r, row_z_r, row_w_r, viewport_r;
  logic signed [31:0] zero_tol_r;

  logic               en;
  logic               mx_valid;
  pp2s_pkg::acc_t     xa, ya, za, wa;
  logic [1:0]         mx_mode;
  logic               pj_valid;
  pp2s_pkg::proj_t    pj;
  logic               rs_valid;
  pp2s_pkg::result_t  rs;

  pp2s_pkg::result_t  q0_r, q1_r;
  logic [1:0]         cnt_r;
  logic               push, pop;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r    <= '0;
      row_y_r    <= '0;
      row_z_r    <= '0;
      row_w_r    <= '0;
      viewport_r <= '0;
      zero_tol_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pp2s_pkg::CFG_ROW_X:    row_x_r    <= cfg_data;
        pp2s_pkg::CFG_ROW_Y:    row_y_r    <= cfg_data;
        pp2s_pkg::CFG_ROW_Z:    row_z_r    <= cfg_data;
        pp2s_pkg::CFG_ROW_W:    row_w_r    <= cfg_data;
        pp2s_pkg::CFG_VIEWPORT: viewport_r <= cfg_data;
        pp2s_pkg::CFG_ZERO_TOL: zero_tol_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipeline advances while the output buffer has room
  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  pp2s_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .pos_x     ($signed(in_tdata[31:0])),
    .pos_y     ($signed(in_tdata[63:32])),
    .pos_z     ($signed(in_tdata[95:64])),
    .mode      (in_tuser),
    .row_x     (row_x_r),
    .row_y     (row_y_r),
    .row_z     (row_z_r),
    .row_w     (row_w_r),
    .out_valid (mx_valid),
    .out_xa    (xa),
    .out_ya    (ya),
    .out_za    (za),
    .out_wa    (wa),
    .out_mode  (mx_mode)
  );

  pp2s_persp u_persp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mx_valid),
    .xa        (xa),
    .ya        (ya),
    .za        (za),
    .wa        (wa),
    .mode      (mx_mode),
    .viewport  (viewport_r),
    .zero_tol  (zero_tol_r),
    .out_valid (pj_valid),
    .out_proj  (pj)
  );

  pp2s_remap u_remap (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pj_valid),
    .in_proj   (pj),
    .viewport  (viewport_r),
    .out_valid (rs_valid),
    .out_res   (rs)
  );

  // two-entry output buffer
  assign push = rs_valid && en;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt_r == 2'd1) q0_r <= rs;
      else q0_r <= q1_r;
      if (push && cnt_r == 2'd2) q1_r <= rs;
    end else if (push) begin
      if (cnt_r == 2'd0) q0_r <= rs;
      else q1_r <= rs;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {q0_r.depth, q0_r.screen_y, q0_r.screen_x};
  assign out_tuser  = {q0_r.w_zero, q0_r.visible};

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("output buffer changed while full and stalled");
  a_vis_not_wz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(q0_r.visible && q0_r.w_zero))
    else $error("visible point flagged with zero w");
  a_wz_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && q0_r.w_zero) |-> q0_r.depth == '0)
    else $error("nonzero depth with zero w");
  a_vis_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && q0_r.visible) |-> (!q0_r.screen_x[31] && !q0_r.screen_y[31]))
    else $error("visible point with negative screen coordinate");
`endif

endmodule

`default_nettype wire

// ===== tb/perspective_project_to_screen_top_tb.sv =====
`default_nettype none

module perspective_project_to_screen_top_tb;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  mode;
  } point_t;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] depth;
    logic        vis;
    logic        wz;
  } screen_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // pos_x, pos_y, pos_z
  logic [1:0]   in_tuser;   // offscreen_mode
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // screen_x, screen_y, depth
  logic [1:0]   out_tuser;  // visible, w_zero
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  // shadow copy of the camera setup
  logic [63:0] cam_row_x, cam_row_y, cam_row_z, cam_row_w, cam_view;
  logic [31:0] cam_tol;

  point_t  pend_pts[$];
  screen_t proj_expect[$];
  int      fails;
  int      burst_left;
  int      gap_left;
  int      stall_cnt;
  logic [7:0] stall_mask;

  perspective_project_to_screen_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v < 0) return 0;
    if (v > pp2s_pkg::ONE_Q16) return pp2s_pkg::ONE_Q16;
    return v;
  endfunction

  // camera row applied to the point, result in Q.18
  function automatic longint row_sum(input logic [63:0] row, input longint px, py, pz);
    longint c0, c1, c2, tr;
    c0 = $signed(row[11:0]);
    c1 = $signed(row[23:12]);
    c2 = $signed(row[35:24]);
    tr = $signed(row[63:36]);
    return px * c0 + py * c1 + pz * c2 + tr * 1024;
  endfunction

  function automatic longint div_q16(input longint a, input longint w);
    return sat_q16((a * 65536) / w);
  endfunction

  function automatic longint root_floor(input logic [63:0] n);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint square_edge(input longint e, input longint dv);
    if (dv == 0) return (e > 0) ? pp2s_pkg::ONE_Q16 : 0;
    return (((e * 65536) / dv) >>> 1) + pp2s_pkg::HALF_Q16;
  endfunction

  function automatic screen_t project_point(input point_t p);
    screen_t o;
    longint px, py, pz, w, xa, ya, sx, sy, dep;
    longint l, r, t, b, nx, ny, cx, cy, dx, dy, d, ex, ey, dv, tol;
    logic [63:0] sq;
    bit behind, in_view, vis, wz;
    px = $signed(p.x);
    py = $signed(p.y);
    pz = $signed(p.z);
    w  = row_sum(cam_row_w, px, py, pz);
    xa = row_sum(cam_row_x, px, py, pz);
    ya = row_sum(cam_row_y, px, py, pz);
    dep = 0;
    vis = 0;
    wz = 0;
    if (w == 0) begin
      wz = 1;
      sx = sat_q16(xa >>> 2);
      sy = sat_q16(ya >>> 2);
    end else begin
      l = cam_view[15:0];
      r = cam_view[31:16];
      t = cam_view[47:32];
      b = cam_view[63:48];
      tol = $signed(cam_tol);
      behind = !(w > tol * 1024);
      nx = div_q16(xa, w);
      ny = div_q16(ya, w);
      dep = div_q16(row_sum(cam_row_z, px, py, pz), w);
      if (behind) begin
        nx = -nx;
        ny = -ny;
      end
      sx = sat_q16(((nx * (r - l)) >>> 16) + (r + l));
      sy = sat_q16(2 * t - (((ny * (t - b)) >>> 16) + (t + b)));
      in_view = sx >= 2 * l && sx <= 2 * r && sy >= 2 * b && sy <= 2 * t;
      vis = in_view && !behind;
      // pull off-screen points onto the circle, then maybe the square
      if (!vis && (p.mode == pp2s_pkg::MODE_SQUARE || p.mode == pp2s_pkg::MODE_CIRCLE)) begin
        cx = r;
        cy = t;
        dx = sx - cx;
        dy = sy - cy;
        sq = 64'(dx * dx) + 64'(dy * dy);
        d = root_floor(sq);
        if (d != 0) begin
          sx = cx + (dx * cy) / d;
          sy = cy + (dy * cy) / d;
        end else begin
          sx = cx;
          sy = cy;
        end
        if (p.mode == pp2s_pkg::MODE_SQUARE) begin
          ex = sx - pp2s_pkg::HALF_Q16;
          ey = sy - pp2s_pkg::HALF_Q16;
          dv = (ey * ey > pp2s_pkg::EIGHTH_Q32) ? (ey < 0 ? -ey : ey) : (ex < 0 ? -ex : ex);
          sx = square_edge(ex, dv);
          sy = square_edge(ey, dv);
        end
        sx = clamp_unit(sx);
        sy = clamp_unit(sy);
      end
    end
    o.sx = sx[31:0];
    o.sy = sy[31:0];
    o.depth = dep[31:0];
    o.vis = vis;
    o.wz = wz;
    return o;
  endfunction

  // ---------------------------------------------------------------- driver

  // request launched at the falling edge in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (pend_pts.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= {pend_pts[0].z, pend_pts[0].y, pend_pts[0].x};
      in_tuser <= pend_pts[0].mode;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // acceptance of a point: predict it and retire it from the pending queue
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      proj_expect.push_back(project_point(pend_pts[0]));
      void'(pend_pts.pop_front());
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(0, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // receiver stall pattern from a randomly reshuffled mask
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_cnt <= 0;
      stall_mask <= 8'hff;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63)
        stall_mask <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      out_tready <= stall_mask[stall_cnt % 8];
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    screen_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (proj_expect.size() == 0) begin
        $display("%0t: unexpected result %h user %b", $time, out_tdata, out_tuser);
        fails++;
      end else begin
        e = proj_expect.pop_front();
        if (out_tdata[31:0] !== e.sx) begin
          $display("%0t: screen_x expected %h actual %h", $time, e.sx, out_tdata[31:0]);
          fails++;
        end
        if (out_tdata[63:32] !== e.sy) begin
          $display("%0t: screen_y expected %h actual %h", $time, e.sy, out_tdata[63:32]);
          fails++;
        end
        if (out_tdata[95:64] !== e.depth) begin
          $display("%0t: depth expected %h actual %h", $time, e.depth, out_tdata[95:64]);
          fails++;
        end
        if (out_tuser[0] !== e.vis) begin
          $display("%0t: visible expected %b actual %b", $time, e.vis, out_tuser[0]);
          fails++;
        end
        if (out_tuser[1] !== e.wz) begin
          $display("%0t: w_zero expected %b actual %b", $time, e.wz, out_tuser[1]);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pp2s_pkg::CFG_ROW_X:    cam_row_x = val;
      pp2s_pkg::CFG_ROW_Y:    cam_row_y = val;
      pp2s_pkg::CFG_ROW_Z:    cam_row_z = val;
      pp2s_pkg::CFG_ROW_W:    cam_row_w = val;
      pp2s_pkg::CFG_VIEWPORT: cam_view = val;
      pp2s_pkg::CFG_ZERO_TOL: cam_tol = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_camera(input logic [63:0] rx, ry, rz, rw, vp, input logic [31:0] tol);
    write_reg(pp2s_pkg::CFG_ROW_X, rx);
    write_reg(pp2s_pkg::CFG_ROW_Y, ry);
    write_reg(pp2s_pkg::CFG_ROW_Z, rz);
    write_reg(pp2s_pkg::CFG_ROW_W, rw);
    write_reg(pp2s_pkg::CFG_VIEWPORT, vp);
    write_reg(pp2s_pkg::CFG_ZERO_TOL, {32'h0, tol});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pack_row(input int c0, c1, c2, tr);
    return {28'(tr), 12'(c2), 12'(c1), 12'(c0)};
  endfunction

  function automatic int small_val(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // plausible row: one dominant coefficient, others and translation small
  function automatic logic [63:0] sane_row(input int lane);
    int c[3];
    for (int i = 0; i < 3; i++) c[i] = small_val(64);
    c[lane] = $urandom_range(256, 1536);
    return pack_row(c[0], c[1], c[2], small_val(4096));
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return small_val(1 << 24);
      default: return small_val(1 << 17);
    endcase
  endfunction

  task automatic wait_drained();
    while (pend_pts.size() > 0 || proj_expect.size() > 0) @(posedge clk);
  endtask

  task automatic add_point(input logic [31:0] x, y, z, input logic [1:0] mode);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.mode = mode;
    pend_pts.push_back(p);
  endtask

  initial begin
    logic [63:0] vp;
    logic [31:0] tol;
    fails = 0;
    burst_left = 0;
    gap_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cam_row_x = 0;
    cam_row_y = 0;
    cam_row_z = 0;
    cam_row_w = 0;
    cam_view = 0;
    cam_tol = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: identity camera, unit viewport
    load_camera(pack_row(1024, 0, 0, 0), pack_row(0, 1024, 0, 0), pack_row(0, 0, 1024, 0),
                pack_row(0, 0, 1024, 0), {16'h0, 16'h8000, 16'h8000, 16'h0}, 32'h0);
    add_point(0, 0, 0, pp2s_pkg::MODE_SQUARE);                 // w exactly zero
    add_point(32'd100, 32'd50, 32'd512, pp2s_pkg::MODE_NONE);  // visible
    for (int m = 0; m < 4; m++) begin
      add_point(32'd1280, 32'd300, 32'd256, 2'(m)); // off screen, all modes
      add_point(-32'sd300, 32'd700, -32'sd256, 2'(m)); // behind, all modes
    end
    add_point(0, 0, -32'sd256, pp2s_pkg::MODE_SQUARE);         // behind at circle center
    add_point(0, 0, -32'sd256, pp2s_pkg::MODE_CIRCLE);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'd1, pp2s_pkg::MODE_SQUARE);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, pp2s_pkg::MODE_CIRCLE);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, pp2s_pkg::MODE_NONE);
    add_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 2'd3);
    add_point(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, pp2s_pkg::MODE_SQUARE);
    add_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0100, pp2s_pkg::MODE_CIRCLE);
    add_point(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ff00, pp2s_pkg::MODE_SQUARE);
    wait_drained();

    // reset-value camera: every point has w of zero
    load_camera(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 40; i++)
      add_point(rand_coord(), rand_coord(), rand_coord(), 2'($urandom));
    wait_drained();

    // all ones, then extreme tolerances on a sane camera
    load_camera('1, '1, '1, '1, '1, 32'hffff_ffff);
    for (int i = 0; i < 60; i++)
      add_point(rand_coord(), rand_coord(), rand_coord(), 2'($urandom));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      vp = {16'($urandom_range(0, 16'h1000)), 16'($urandom_range(16'h4000, 16'hffff)),
            16'($urandom_range(16'h4000, 16'hffff)), 16'($urandom_range(0, 16'h1000))};
      tol = small_val(256);
      if (ph == 1) tol = 32'h8000_0000;
      if (ph == 2) tol = 32'h7fff_ffff;
      if (ph == 7) begin
        load_camera({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end else begin
        load_camera(sane_row(0), sane_row(1), sane_row(2), sane_row(2), vp, tol);
      end
      for (int i = 0; i < 160; i++) begin
        // mostly points in front with modest range, some anything
        if ($urandom_range(0, 4) != 0)
          add_point(small_val(1 << 16), small_val(1 << 16),
                    ($urandom_range(0, 5) == 0) ? small_val(1 << 14) : $urandom_range(64, 1 << 16),
                    2'($urandom_range(0, 2)));
        else
          add_point(rand_coord(), rand_coord(), rand_coord(), 2'($urandom));
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (fails == 0)
      $display("perspective_project_to_screen_top_tb: PASS");
    else
      $display("perspective_project_to_screen_top_tb: FAIL");
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("perspective_project_to_screen_top_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
